/* rtl/core/hlr_pkg.sv */
// hlr_pkg: types, constants and small arithmetic helpers for highlight_recovery_pixel
// no dependencies; imported by hlr_cfg_regs and highlight_recovery_pixel
package hlr_pkg;

    // one input item: three raw channels
    typedef struct packed {
        logic [15:0] raw_red;
        logic [15:0] raw_green;
        logic [15:0] raw_blue;
    } pix_in_t;

    // one result item: three recovered channels
    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } pix_out_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MATRIX_RED    = 2'd0,
        REG_MATRIX_GREEN  = 2'd1,
        REG_MATRIX_BLUE   = 2'd2,
        REG_BALANCE_GAINS = 2'd3
    } cfg_index_t;

    // register contents handed to the datapath
    typedef struct packed {
        logic [47:0] row_red;
        logic [47:0] row_green;
        logic [47:0] row_blue;
        logic [47:0] gains;
    } cfg_t;

    localparam int          CFG_W         = 48;
    localparam logic [47:0] RST_ROW_RED   = 48'h0000_0000_1000;
    localparam logic [47:0] RST_ROW_GREEN = 48'h0000_1000_0000;
    localparam logic [47:0] RST_ROW_BLUE  = 48'h1000_0000_0000;
    localparam logic [47:0] RST_GAINS     = 48'h1000_1000_1000;

    localparam logic [15:0] CLIP_LEVEL   = 16'd65535;
    localparam logic [15:0] THRESH_LEVEL = 16'd52428;
    localparam logic [17:0] WHITE_SUM    = 18'd196605;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [17:0] Y_MAX        = 18'd196607;
    localparam logic [20:0] RECIP3       = 21'd699051;

    // floor(x / 3) for x below 2^20, by reciprocal multiply
    function automatic logic [18:0] div3_q(input logic [19:0] x);
        logic [40:0] p;
        p = {21'b0, x} * {20'b0, RECIP3};
        return p[39:21];
    endfunction

    // floor(z * 2^16 / (3 * 65535)) for z up to 5 * 196605
    function automatic logic [18:0] ratio_q16(input logic [19:0] z);
        logic [20:0] t;
        logic [3:0]  q;
        logic [19:0] v;
        t = {1'b0, z} + {17'b0, z[19:16]} + 21'd1;
        q = t[19:16];
        v = z + {16'b0, q};
        return div3_q(v);
    endfunction

endpackage

/* rtl/core/hlr_cfg_regs.sv */
// hlr_cfg_regs: colour matrix and white-balance gain registers
// depends on hlr_pkg
module hlr_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  hlr_pkg::cfg_index_t cfg_index,
    input  logic [47:0]         cfg_data,
    output hlr_pkg::cfg_t       cfg
);
    import hlr_pkg::*;

    cfg_t cfg_reg;

    // register writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_red   <= RST_ROW_RED;
            cfg_reg.row_green <= RST_ROW_GREEN;
            cfg_reg.row_blue  <= RST_ROW_BLUE;
            cfg_reg.gains     <= RST_GAINS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MATRIX_RED:    cfg_reg.row_red   <= cfg_data;
                REG_MATRIX_GREEN:  cfg_reg.row_green <= cfg_data;
                REG_MATRIX_BLUE:   cfg_reg.row_blue  <= cfg_data;
                REG_BALANCE_GAINS: cfg_reg.gains     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/highlight_recovery_pixel.sv */
// highlight_recovery_pixel: top level, twelve-stage highlight recovery pipeline
// depends on hlr_pkg and hlr_cfg_regs
// One pixel per clock in and out while the result port is not stalled. An accepted item passes
// through the stage registers in order to the result port; the stages hold the matrix
// products, reciprocal divides by 3*65535, up to two squarings of the saturation factor,
// the blend products, the final mix product, the rounding and the divide by 3. Every stage
// holds its own valid bit and refills whenever the stage after it moves on, so a stalled
// result port only blocks the input once all twelve stages are full, and bubbles close up.
// Configuration registers are plain writes and should only change while the pipeline is
// empty; COEF_FRAC_BITS sets the fractional bits of the coefficients and gains.
module highlight_recovery_pixel #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hlr_pkg::pix_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hlr_pkg::pix_out_t   m_data,
    input  logic                cfg_wr_en,
    input  hlr_pkg::cfg_index_t cfg_index,
    input  logic [47:0]         cfg_data
);
    import hlr_pkg::*;

    localparam int NSTG  = 12;
    localparam int S_IN  = 0;   // input capture
    localparam int S_MUL = 1;   // matrix and gain products
    localparam int S_ACC = 2;   // row sums, scaled channels
    localparam int S_STA = 3;   // clip statistics, differences to the mean
    localparam int S_DIV = 4;   // m1, m2, s
    localparam int S_SQ1 = 5;   // first squaring
    localparam int S_SQ2 = 6;   // second squaring
    localparam int S_BLD = 7;   // blend products
    localparam int S_FAC = 8;   // factor m
    localparam int S_MIX = 9;   // mix products
    localparam int S_RND = 10;  // rounding and clamp
    localparam int S_OUT = 11;  // divide by 3, output register

    localparam int          NUM_W      = 58;
    localparam int          SHIFT      = COEF_FRAC_BITS + 16;
    localparam logic [NUM_W-1:0] ROUND_HALF = NUM_W'(3) << (COEF_FRAC_BITS + 15);

    cfg_t cfg;

    hlr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // payload registers
    pix_in_t            raw_reg;
    logic signed [32:0] mprod_reg [0:2][0:2];
    logic [31:0]        gprod_reg [0:2];
    logic signed [34:0] acc_reg   [0:2];
    logic [15:0]        val_reg   [0:2];
    logic signed [38:0] d_reg     [S_STA:S_FAC][0:2];
    logic signed [36:0] total_reg [S_STA:S_MIX];
    logic [1:0]         cnt_reg   [S_STA:S_BLD];
    logic [15:0]        vmax_reg;
    logic [17:0]        sum_reg;
    logic [15:0]        s0_reg;
    logic [15:0]        m1_reg    [S_DIV:S_SQ2];
    logic [17:0]        m2_reg    [S_DIV:S_SQ2];
    logic [15:0]        s1_reg;
    logic [15:0]        s2_reg;
    logic [33:0]        pa_reg;
    logic [32:0]        pb_reg;
    logic [16:0]        mfac_reg;
    logic signed [55:0] dm_reg    [0:2];
    logic [17:0]        y_reg     [0:2];
    pix_out_t           out_reg;

    // next values
    logic signed [32:0] mprod_next [0:2][0:2];
    logic [31:0]        gprod_next [0:2];
    logic signed [34:0] acc_next   [0:2];
    logic [15:0]        val_next   [0:2];
    logic signed [38:0] d_next     [0:2];
    logic signed [36:0] total_next;
    logic [1:0]         cnt_next;
    logic [15:0]        vmax_next;
    logic [17:0]        sum_next;
    logic [15:0]        s0_next;
    logic [15:0]        m1_next;
    logic [17:0]        m2_next;
    logic [15:0]        s1_next;
    logic [15:0]        s2_next;
    logic [33:0]        pa_next;
    logic [32:0]        pb_next;
    logic [16:0]        mfac_next;
    logic signed [55:0] dm_next    [0:2];
    logic [17:0]        y_next     [0:2];
    pix_out_t           out_next;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[S_IN];
    assign m_valid = vld_reg[S_OUT];
    assign m_data  = out_reg;

    // stage 1: matrix products and gain products
    always_comb begin
        logic [15:0] raw [0:2];
        logic [47:0] rows [0:2];
        raw[0]  = raw_reg.raw_red;
        raw[1]  = raw_reg.raw_green;
        raw[2]  = raw_reg.raw_blue;
        rows[0] = cfg.row_red;
        rows[1] = cfg.row_green;
        rows[2] = cfg.row_blue;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mprod_next[i][j] = $signed(rows[i][16*j +: 16]) * $signed({1'b0, raw[j]});
            end
            gprod_next[i] = {16'b0, cfg.gains[16*i +: 16]} * {16'b0, raw[i]};
        end
    end

    // stage 2: row sums and clipped scaled channels
    always_comb begin
        logic [31:0] sc;
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = 35'(mprod_reg[i][0]) + 35'(mprod_reg[i][1]) + 35'(mprod_reg[i][2]);
            sc = gprod_reg[i] >> COEF_FRAC_BITS;
            val_next[i] = (sc > {16'b0, CLIP_LEVEL}) ? CLIP_LEVEL : sc[15:0];
        end
    end

    // stage 3: clip count, maximum, sum, and each row's distance from the mean
    always_comb begin
        logic signed [38:0] a [0:2];
        logic signed [38:0] tot;
        logic [1:0]         c;
        logic [15:0]        mx;
        for (int i = 0; i < 3; i++) begin
            a[i] = 39'(acc_reg[i]);
        end
        tot = a[0] + a[1] + a[2];
        for (int i = 0; i < 3; i++) begin
            d_next[i] = (a[i] <<< 1) + a[i] - tot;
        end
        total_next = tot[36:0];
        c = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (val_reg[i] > THRESH_LEVEL) begin
                c = c + 2'd1;
            end
        end
        cnt_next = c;
        mx = (val_reg[0] > val_reg[1]) ? val_reg[0] : val_reg[1];
        vmax_next = (val_reg[2] > mx) ? val_reg[2] : mx;
        sum_next = {2'b0, val_reg[0]} + {2'b0, val_reg[1]} + {2'b0, val_reg[2]};
    end

    // stage 4: m1 = 5*(65535-max), m2 and s through the reciprocal of 3*65535
    always_comb begin
        logic [17:0] rest;
        logic [18:0] m1w;
        logic [18:0] s0w;
        logic [18:0] m2w;
        rest    = WHITE_SUM - sum_reg;
        m1w     = {3'b0, CLIP_LEVEL - vmax_reg} * 19'd5;
        s0w     = ratio_q16({2'b0, rest});
        m2w     = ratio_q16({2'b0, rest} * 20'd5);
        m1_next = m1w[15:0];
        s0_next = s0w[15:0];
        m2_next = m2w[17:0];
    end

    // stages 5 and 6: square s once when the count is at least two, and again when it is three
    always_comb begin
        logic [31:0] sq1;
        logic [31:0] sq2;
        sq1     = {16'b0, s0_reg} * {16'b0, s0_reg};
        s1_next = (cnt_reg[S_DIV] >= 2'd2) ? sq1[31:16] : s0_reg;
        sq2     = {16'b0, s1_reg} * {16'b0, s1_reg};
        s2_next = (cnt_reg[S_SQ1] == 2'd3) ? sq2[31:16] : s1_reg;
    end

    // stage 7: blend products
    always_comb begin
        pa_next = {18'b0, s2_reg} * {16'b0, m2_reg[S_SQ2]};
        pb_next = {16'b0, ONE_Q16 - {1'b0, s2_reg}} * {17'b0, m1_reg[S_SQ2]};
    end

    // stage 8: factor m, one when nothing clips or the blend reaches one
    always_comb begin
        logic [34:0] bl;
        bl = {1'b0, pa_reg} + {2'b0, pb_reg};
        if (cnt_reg[S_BLD] == 2'd0 || bl[34:16] >= {2'b0, ONE_Q16}) begin
            mfac_next = ONE_Q16;
        end else begin
            mfac_next = bl[32:16];
        end
    end

    // stage 9: distance from the mean scaled by m
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dm_next[i] = d_reg[S_FAC][i] * $signed({1'b0, mfac_reg});
        end
    end

    // stage 10: add the mean term, round, clear negatives, clamp
    always_comb begin
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        xr;
        logic [NUM_W-1:0]        xs;
        for (int i = 0; i < 3; i++) begin
            num = $signed({{(NUM_W-53){total_reg[S_MIX][36]}}, total_reg[S_MIX], 16'b0})
                + $signed({{(NUM_W-56){dm_reg[i][55]}}, dm_reg[i]});
            xr  = $unsigned(num) + ROUND_HALF;
            xs  = xr >> SHIFT;
            if (num[NUM_W-1]) begin
                y_next[i] = 18'd0;
            end else if (xs > NUM_W'(Y_MAX)) begin
                y_next[i] = Y_MAX;
            end else begin
                y_next[i] = xs[17:0];
            end
        end
    end

    // stage 11: final divide by 3
    always_comb begin
        logic [18:0] q [0:2];
        for (int i = 0; i < 3; i++) begin
            q[i] = div3_q({2'b0, y_reg[i]});
        end
        out_next.out_red   = q[0][15:0];
        out_next.out_green = q[1][15:0];
        out_next.out_blue  = q[2][15:0];
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[S_IN]) begin
                vld_reg[S_IN] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // payload registers, loaded with their stage
    always_ff @(posedge aclk) begin
        if (en[S_IN]) begin
            raw_reg <= s_data;
        end
        if (en[S_MUL]) begin
            mprod_reg <= mprod_next;
            gprod_reg <= gprod_next;
        end
        if (en[S_ACC]) begin
            acc_reg <= acc_next;
            val_reg <= val_next;
        end
        if (en[S_STA]) begin
            d_reg[S_STA]     <= d_next;
            total_reg[S_STA] <= total_next;
            cnt_reg[S_STA]   <= cnt_next;
            vmax_reg         <= vmax_next;
            sum_reg          <= sum_next;
        end
        if (en[S_DIV]) begin
            s0_reg         <= s0_next;
            m1_reg[S_DIV]  <= m1_next;
            m2_reg[S_DIV]  <= m2_next;
        end
        if (en[S_SQ1]) begin
            s1_reg <= s1_next;
        end
        if (en[S_SQ2]) begin
            s2_reg <= s2_next;
        end
        for (int k = S_SQ1; k <= S_SQ2; k++) begin
            if (en[k]) begin
                m1_reg[k] <= m1_reg[k-1];
                m2_reg[k] <= m2_reg[k-1];
            end
        end
        for (int k = S_DIV; k <= S_BLD; k++) begin
            if (en[k]) begin
                cnt_reg[k] <= cnt_reg[k-1];
            end
        end
        for (int k = S_DIV; k <= S_FAC; k++) begin
            if (en[k]) begin
                d_reg[k] <= d_reg[k-1];
            end
        end
        for (int k = S_DIV; k <= S_MIX; k++) begin
            if (en[k]) begin
                total_reg[k] <= total_reg[k-1];
            end
        end
        if (en[S_BLD]) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (en[S_FAC]) begin
            mfac_reg <= mfac_next;
        end
        if (en[S_MIX]) begin
            dm_reg <= dm_next;
        end
        if (en[S_RND]) begin
            y_reg <= y_next;
        end
        if (en[S_OUT]) begin
            out_reg <= out_next;
        end
    end

    // an empty output register means every stage can move, so the input is open
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[S_OUT] |-> s_ready)
        else $error("input blocked with an empty output register");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[S_IN])
        else $error("accepted item lost at the input stage");

    // the desaturation factor never exceeds one
    a_factor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_FAC] |-> mfac_reg <= ONE_Q16)
        else $error("factor m above one");

    // a held stage keeps its item while the stage after it is blocked
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_SQ1] && !en[S_SQ1] |=> vld_reg[S_SQ1] && $stable(s1_reg))
        else $error("stalled stage dropped or changed its item");

endmodule
